FILE: hdl/osd_pkg.sv
// shared types and constants for the osc message deframer
// no dependencies; used by osd_parser, osd_out_queue and the top level
package osd_pkg;

   localparam int MAX_TYPES = 16;
   localparam int MAX_PATH  = 64;

   localparam int CNT_W     = $clog2(MAX_TYPES + 1);
   localparam int TAG_IDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int PLEN_W    = $clog2(MAX_PATH + 1);
   localparam int ARG_IDX_W = 4;

   // result queue, depth must be a power of two
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_F     = 8'h66;

   typedef enum logic [2:0] {
      PH_PATH,
      PH_COMMA,
      PH_TAGS,
      PH_ARG_STR,
      PH_ARG_WORD,
      PH_DROP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PATH,
      KIND_TYPE,
      KIND_STR,
      KIND_INT,
      KIND_FLOAT,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NO_COMMA,
      ST_UNKNOWN_TAG,
      ST_TRUNCATED,
      ST_TOO_MANY
   } status_type;

   typedef struct packed {
      kind_type               kind;
      logic [ARG_IDX_W-1:0]   arg_index;
      logic [31:0]            value;
      status_type             status;
      logic                   eom;
   } osd_rec_type;

   // up to two records per byte; b only ever holds an end record
   typedef struct packed {
      logic        a_valid;
      logic        b_valid;
      osd_rec_type a;
      osd_rec_type b;
   } osd_push_type;

endpackage

FILE: hdl/osd_parser.sv
// byte-level parse state, tag store and record generation
// depends on osd_pkg
module osd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output osd_pkg::osd_push_type push
);
   import osd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [1:0]          gpos_ff, gpos_in;
   logic                se_ff, se_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [31:0]         ws_ff, ws_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic                word_int_ff, word_int_in;

   logic [7:0]          tag_store [MAX_TYPES];

   logic                b_zero, se_now, group_end, tag_full;
   logic                path_emit, tag_emit, tag_over;
   logic                walk_go, walk_end, walk_is_s, walk_is_word, walk_bad;
   logic [CNT_W-1:0]    walk_ptr;
   logic [7:0]          walk_tag;
   logic                early_end;

   logic                prim_valid, end_valid;
   osd_rec_type         prim_rec, end_rec;

   assign b_zero    = (data_byte == 8'd0);
   assign se_now    = se_ff | b_zero;
   assign group_end = (gpos_ff == 2'd3) && b_zero;
   assign tag_full  = (count_ff >= CNT_W'(MAX_TYPES));
   assign path_emit = (phase_ff == PH_PATH) && !se_now && (plen_ff < PLEN_W'(MAX_PATH));
   assign tag_emit  = (phase_ff == PH_TAGS) && !se_now && !tag_full;
   assign tag_over  = (phase_ff == PH_TAGS) && !se_now && tag_full;

   // walk to the next argument: from the tag string start at 0, else step on
   assign walk_go = accept && (((phase_ff == PH_TAGS) && group_end)
                  || ((phase_ff == PH_ARG_STR) && group_end)
                  || ((phase_ff == PH_ARG_WORD) && (gpos_ff == 2'd3)));
   assign walk_ptr     = (phase_ff == PH_TAGS) ? '0 : ptr_ff + 1'b1;
   assign walk_end     = (walk_ptr >= count_ff);
   assign walk_tag     = tag_store[walk_ptr[TAG_IDX_W-1:0]];
   assign walk_is_s    = (walk_tag == CHAR_S);
   assign walk_is_word = (walk_tag == CHAR_I) || (walk_tag == CHAR_F);
   assign walk_bad     = !walk_end && !walk_is_s && !walk_is_word;

   assign early_end = accept && (((phase_ff == PH_COMMA) && (data_byte != CHAR_COMMA))
                    || tag_over || walk_go && (walk_end || walk_bad));

   // next state
   always_comb begin
      phase_in    = phase_ff;
      gpos_in     = gpos_ff;
      se_in       = se_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      ws_in       = ws_ff;
      plen_in     = plen_ff;
      word_int_in = word_int_ff;
      if (accept) begin
         case (phase_ff)
            PH_PATH: begin
               se_in = se_now;
               if (path_emit) plen_in = plen_ff + 1'b1;
               if (group_end) begin
                  phase_in = PH_COMMA;
                  se_in    = 1'b0;
               end
            end
            PH_COMMA: begin
               phase_in = (data_byte == CHAR_COMMA) ? PH_TAGS : PH_DROP;
            end
            PH_TAGS: begin
               se_in = se_now;
               if (tag_over) begin
                  phase_in = PH_DROP;
               end else begin
                  if (tag_emit) count_in = count_ff + 1'b1;
                  if (group_end) ptr_in = '0;
               end
            end
            PH_ARG_STR: begin
               se_in = se_now;
               if (group_end) ptr_in = ptr_ff + 1'b1;
            end
            PH_ARG_WORD: begin
               ws_in = {ws_ff[23:0], data_byte};
               if (gpos_ff == 2'd3) ptr_in = ptr_ff + 1'b1;
            end
            default: begin
            end
         endcase
         if (walk_go) begin
            if (walk_end || walk_bad) begin
               phase_in = PH_DROP;
            end else if (walk_is_s) begin
               phase_in = PH_ARG_STR;
               se_in    = 1'b0;
            end else begin
               phase_in    = PH_ARG_WORD;
               ws_in       = '0;
               word_int_in = (walk_tag == CHAR_I);
            end
         end
         if (last_byte) begin
            phase_in = PH_PATH;
            gpos_in  = 2'd0;
            se_in    = 1'b0;
            count_in = '0;
            ptr_in   = '0;
            ws_in    = '0;
            plen_in  = '0;
         end else begin
            gpos_in = gpos_ff + 2'd1;
         end
      end
   end

   // records for this byte
   always_comb begin
      prim_valid         = 1'b0;
      prim_rec.kind      = KIND_PATH;
      prim_rec.arg_index = '0;
      prim_rec.value     = {24'd0, data_byte};
      prim_rec.status    = ST_OK;
      prim_rec.eom       = 1'b0;
      end_valid          = 1'b0;
      end_rec.kind       = KIND_END;
      end_rec.arg_index  = '0;
      end_rec.value      = '0;
      end_rec.status     = ST_OK;
      end_rec.eom        = 1'b1;
      if (accept) begin
         case (phase_ff)
            PH_PATH: begin
               prim_valid = path_emit;
            end
            PH_COMMA: begin
               end_rec.status = ST_NO_COMMA;
            end
            PH_TAGS: begin
               prim_valid         = tag_emit;
               prim_rec.kind      = KIND_TYPE;
               prim_rec.arg_index = ARG_IDX_W'(count_ff);
               if (tag_over) end_rec.status = ST_TOO_MANY;
            end
            PH_ARG_STR: begin
               prim_valid         = !se_now;
               prim_rec.kind      = KIND_STR;
               prim_rec.arg_index = ARG_IDX_W'(ptr_ff);
            end
            PH_ARG_WORD: begin
               prim_valid         = (gpos_ff == 2'd3);
               prim_rec.kind      = word_int_ff ? KIND_INT : KIND_FLOAT;
               prim_rec.arg_index = ARG_IDX_W'(ptr_ff);
               prim_rec.value     = {ws_ff[23:0], data_byte};
            end
            default: begin
            end
         endcase
         if (walk_go && walk_end) end_rec.status = ST_OK;
         else if (walk_go && walk_bad) end_rec.status = ST_UNKNOWN_TAG;
         if (early_end) begin
            end_valid = 1'b1;
         end else if (last_byte && (phase_ff != PH_DROP)) begin
            end_valid      = 1'b1;
            end_rec.status = ST_TRUNCATED;
         end
      end
      if (prim_valid) begin
         push.a_valid = 1'b1;
         push.a       = prim_rec;
         push.b_valid = end_valid;
      end else begin
         push.a_valid = end_valid;
         push.a       = end_rec;
         push.b_valid = 1'b0;
      end
      push.b = end_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PATH;
         gpos_ff     <= 2'd0;
         se_ff       <= 1'b0;
         count_ff    <= '0;
         ptr_ff      <= '0;
         ws_ff       <= '0;
         plen_ff     <= '0;
         word_int_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         gpos_ff     <= gpos_in;
         se_ff       <= se_in;
         count_ff    <= count_in;
         ptr_ff      <= ptr_in;
         ws_ff       <= ws_in;
         plen_ff     <= plen_in;
         word_int_ff <= word_int_in;
      end
   end

   // tag store has no reset, the walk only reads entries of this datagram
   always_ff @(posedge clock) begin
      if (accept && tag_emit) tag_store[count_ff[TAG_IDX_W-1:0]] <= data_byte;
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> (phase_ff == PH_PATH) && (count_ff == '0) && (ptr_ff == '0))
      else $error("parse state not cleared after last byte");
   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      push.b_valid |-> push.a_valid && push.b.eom && (push.b.kind == KIND_END))
      else $error("second record is not a lone end record");
   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      push.a_valid && (push.a.kind == KIND_END) |-> !push.b_valid)
      else $error("record follows an end record");
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(MAX_TYPES)) && (ptr_ff <= count_ff))
      else $error("tag count or argument pointer out of range");
`endif

endmodule

FILE: hdl/osd_out_queue.sv
// small result queue: takes up to two records per cycle and hands out
// one per cycle unless out_stall holds it; depends on osd_pkg
module osd_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  osd_pkg::osd_push_type push,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output osd_pkg::osd_rec_type  out_rec
);
   import osd_pkg::*;

   osd_rec_type            mem [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]  wr_ff, wr_in;
   logic [OUTQ_PTR_W-1:0]  rd_ff, rd_in;
   logic [OUTQ_CNT_W-1:0]  count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_rec   = mem[rd_ff];
   assign pop       = out_valid && !out_stall;
   // keep room for a two-record item
   assign full      = (count_ff > OUTQ_CNT_W'(OUTQ_DEPTH - 2));

   assign wr_in    = wr_ff + OUTQ_PTR_W'(push.a_valid) + OUTQ_PTR_W'(push.b_valid);
   assign rd_in    = rd_ff + OUTQ_PTR_W'(pop);
   assign count_in = count_ff + OUTQ_CNT_W'(push.a_valid) + OUTQ_CNT_W'(push.b_valid)
                   - OUTQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.a_valid) mem[wr_ff] <= push.a;
      if (push.b_valid) mem[wr_ff + 1'b1] <= push.b;
   end

endmodule

FILE: hdl/osc_message_deframer_top.sv
// osc message deframer: one datagram byte per item in, parse records out
// a byte's records are written into the registered result queue when the byte is taken
// throughput: one byte per cycle unless stalled; a byte gives at most two records and the
// four-entry result queue stalls input once it holds three or more
// reset: synchronous, clears parse state and queue; the tag store is not cleared
// depends on osd_pkg, osd_parser, osd_out_queue
module osc_message_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_arg_index,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_end_of_message
);
   import osd_pkg::*;

   osd_push_type push;
   osd_rec_type  out_rec;
   logic         accept;
   logic         full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   osd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   osd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rec   (out_rec)
   );

   assign rsp_kind           = out_rec.kind;
   assign rsp_arg_index      = out_rec.arg_index;
   assign rsp_value          = out_rec.value;
   assign rsp_status         = out_rec.status;
   assign rsp_end_of_message = out_rec.eom;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// testbench for osc_message_deframer_top: directed and random datagrams fed byte by byte
// depends on osd_pkg and the deframer rtl; a scoreboard class predicts and checks records

module tb;
   import osd_pkg::*;

   localparam int LIMIT        = 400000;
   localparam int RANDOM_BYTES = 450;
   localparam int SETTLE       = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_arg_index;
   logic [31:0] rsp_value;
   logic [2:0]  rsp_status;
   logic        rsp_end_of_message;

   class record_checker;
      osd_rec_type pending_recs[$];
      int          errors;
      int          seen;
      phase_type   ph;
      bit [1:0]    grp_pos;
      bit          str_done;
      bit [7:0]    tag_mem[MAX_TYPES];
      int          tag_cnt;
      int          arg_ptr;
      int          path_len;
      bit [31:0]   word_acc;

      function new();
         errors = 0;
         seen   = 0;
         restart();
      endfunction

      function void restart();
         ph       = PH_PATH;
         grp_pos  = 2'd0;
         str_done = 1'b0;
         tag_cnt  = 0;
         arg_ptr  = 0;
         word_acc = 32'h0;
         path_len = 0;
      endfunction

      function int pending();
         return pending_recs.size();
      endfunction

      function void push_rec(kind_type k, int idx, bit [31:0] v, status_type st, bit eom);
         osd_rec_type r;
         r.kind      = k;
         r.arg_index = idx[3:0];
         r.value     = v;
         r.status    = st;
         r.eom       = eom;
         pending_recs.push_back(r);
      endfunction

      function void close_msg(status_type st);
         ph = PH_DROP;
         push_rec(KIND_END, 0, 32'h0, st, 1'b1);
      endfunction

      // move on to the argument at arg_ptr, or end the message
      function void walk_args();
         bit [7:0] tag;
         if (arg_ptr >= tag_cnt || arg_ptr >= MAX_TYPES) begin
            close_msg(ST_OK);
            return;
         end
         tag = tag_mem[arg_ptr];
         if (tag == CHAR_S) begin
            ph       = PH_ARG_STR;
            str_done = 1'b0;
         end else if (tag == CHAR_I || tag == CHAR_F) begin
            ph       = PH_ARG_WORD;
            word_acc = 32'h0;
         end else begin
            close_msg(ST_UNKNOWN_TAG);
         end
      endfunction

      function void take_byte(bit [7:0] b, bit is_last);
         bit       grp_end;
         kind_type wk;
         grp_end = (grp_pos == 2'd3) && (b == 8'h00);
         case (ph)
            PH_PATH: begin
               if (b == 8'h00) str_done = 1'b1;
               if (!str_done && path_len < MAX_PATH) begin
                  push_rec(KIND_PATH, 0, {24'h0, b}, ST_OK, 1'b0);
                  path_len++;
               end
               if (grp_end) begin
                  ph       = PH_COMMA;
                  str_done = 1'b0;
               end
            end
            PH_COMMA: begin
               if (b != CHAR_COMMA) close_msg(ST_NO_COMMA);
               else ph = PH_TAGS;
            end
            PH_TAGS: begin
               if (b == 8'h00) str_done = 1'b1;
               if (!str_done && tag_cnt >= MAX_TYPES) begin
                  close_msg(ST_TOO_MANY);
               end else begin
                  if (!str_done) begin
                     tag_mem[tag_cnt] = b;
                     push_rec(KIND_TYPE, tag_cnt, {24'h0, b}, ST_OK, 1'b0);
                     tag_cnt++;
                  end
                  if (grp_end) begin
                     arg_ptr = 0;
                     walk_args();
                  end
               end
            end
            PH_ARG_STR: begin
               if (b == 8'h00) str_done = 1'b1;
               if (!str_done) push_rec(KIND_STR, arg_ptr, {24'h0, b}, ST_OK, 1'b0);
               if (grp_end) begin
                  arg_ptr++;
                  walk_args();
               end
            end
            PH_ARG_WORD: begin
               word_acc = {word_acc[23:0], b};
               if (grp_pos == 2'd3) begin
                  wk = (tag_mem[arg_ptr % MAX_TYPES] == CHAR_I) ? KIND_INT : KIND_FLOAT;
                  push_rec(wk, arg_ptr, word_acc, ST_OK, 1'b0);
                  arg_ptr++;
                  walk_args();
               end
            end
            default: begin
            end
         endcase
         if (is_last) begin
            if (ph != PH_DROP) close_msg(ST_TRUNCATED);
            restart();
         end else begin
            grp_pos++;
         end
      endfunction

      function void check_record(logic [2:0] kind, logic [3:0] idx, logic [31:0] val,
                                 logic [2:0] st, logic eom);
         osd_rec_type e;
         seen++;
         if (pending_recs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("record %0d: none expected, got kind %0d idx %0d value %h ",
                        seen, kind, idx, val, "status %0d eom %b", st, eom);
            return;
         end
         e = pending_recs.pop_front();
         if (kind !== e.kind || idx !== e.arg_index || val !== e.value ||
             st !== e.status || eom !== e.eom) begin
            errors++;
            if (errors <= 10)
               $display("record %0d: expected kind %0d idx %0d value %h status %0d eom %b, ",
                        seen, e.kind, e.arg_index, e.value, e.status, e.eom,
                        "got kind %0d idx %0d value %h status %0d eom %b",
                        kind, idx, val, st, eom);
         end
      endfunction
   endclass

   record_checker sb = new();
   int  cycles = 0;
   int  stall_hold = 0;
   int  calm_left = 0;
   bit  calm = 1'b0;
   bit  burst = 1'b0;

   osc_message_deframer_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_arg_index      (rsp_arg_index),
      .rsp_value          (rsp_value),
      .rsp_status         (rsp_status),
      .rsp_end_of_message (rsp_end_of_message)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.take_byte(req_data_byte, req_last_byte);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_record(rsp_kind, rsp_arg_index, rsp_value, rsp_status, rsp_end_of_message);
   end

   // receiver back-pressure: calm stretches, short stalls and a few long ones
   always @(negedge clock) begin
      int r;
      if (calm_left == 0) begin
         calm      = ($urandom_range(2) == 0);
         calm_left = $urandom_range(300, 50);
      end else begin
         calm_left--;
      end
      r = $urandom_range(99);
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else if (calm || r < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         if (r >= 95) stall_hold = $urandom_range(30, 10);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (burst || r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // each call starts and ends at a falling edge
   task automatic send_byte(input bit [7:0] b, input bit is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_dgram(input bit [7:0] q[$]);
      int i;
      for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // zero-terminated string padded to a 4-byte group; junk may follow the first zero
   function automatic void pad_str(ref bit [7:0] q[$], input bit [7:0] chars[$],
                                   input bit junk);
      foreach (chars[k]) q.push_back(chars[k]);
      q.push_back(8'h00);
      if (q.size() % 4 != 0) begin
         while (q.size() % 4 != 3) q.push_back(junk ? 8'($urandom_range(255)) : 8'h00);
         q.push_back(8'h00);
      end
   endfunction

   function automatic void make_msg(ref bit [7:0] q[$], input int plen, input int ntags,
                                    input bit bad_tag);
      bit [7:0] chars[$];
      bit [7:0] tags[$];
      bit [7:0] t;
      bit       junk;
      int       k;
      junk = ($urandom_range(3) == 0);
      repeat (plen) chars.push_back(8'($urandom_range(255, 1)));
      pad_str(q, chars, junk);
      tags.push_back(CHAR_COMMA);
      repeat (ntags) begin
         case ($urandom_range(2))
            0: tags.push_back(CHAR_S);
            1: tags.push_back(CHAR_I);
            default: tags.push_back(CHAR_F);
         endcase
      end
      if (bad_tag && ntags > 0) begin
         do t = 8'($urandom_range(255, 1));
         while (t == CHAR_S || t == CHAR_I || t == CHAR_F);
         tags[$urandom_range(ntags, 1)] = t;
      end
      pad_str(q, tags, junk);
      for (k = 1; k < tags.size(); k++) begin
         if (tags[k] == CHAR_S) begin
            chars.delete();
            repeat ($urandom_range(6)) chars.push_back(8'($urandom_range(255, 1)));
            pad_str(q, chars, junk);
         end else begin
            repeat (4) q.push_back(8'($urandom_range(255)));
         end
      end
   endfunction

   initial begin
      bit [7:0] q[$];
      bit [7:0] chars[$];
      bit [7:0] b;
      int       sent;
      int       r;
      int       plen;
      int       ntags;
      int       n;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero inside a path group, float argument with extreme bits
      q = '{8'h2f, 8'h00, 8'h55, 8'h00, 8'h2c, 8'h66, 8'h00, 8'h00,
            8'h80, 8'h00, 8'h00, 8'h01};
      send_dgram(q);
      // empty path, missing comma, trailing bytes dropped
      q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h3b, 8'hff, 8'h00};
      send_dgram(q);
      // empty tag list
      q = '{8'h2f, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h00, 8'h00, 8'h00};
      send_dgram(q);
      // unknown tag followed by a trailing byte
      q = '{8'h2f, 8'h2f, 8'h2f, 8'h00, 8'h2c, 8'h78, 8'h00, 8'h00, 8'h01};
      send_dgram(q);
      // early end inside a string argument
      q = '{8'hff, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h73, 8'h00, 8'h00, 8'h61};
      send_dgram(q);
      // one-byte datagram
      q = '{8'hff};
      send_dgram(q);
      hold_until_drained();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         q.delete();
         burst = ($urandom_range(4) == 0);
         r     = $urandom_range(99);
         plen  = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(12);
         ntags = ($urandom_range(9) == 0) ? $urandom_range(16, 12) : $urandom_range(5);
         if (r < 60) begin
            make_msg(q, plen, ntags, 1'b0);
         end else if (r < 68) begin
            make_msg(q, plen, ntags, 1'b0);
            n = $urandom_range(q.size() - 1, 1);
            q = q[0:n-1];
         end else if (r < 76) begin
            make_msg(q, plen, ntags, 1'b0);
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
         end else if (r < 82) begin
            chars.delete();
            repeat (plen) chars.push_back(8'($urandom_range(255, 1)));
            pad_str(q, chars, 1'b0);
            do b = 8'($urandom_range(255));
            while (b == CHAR_COMMA);
            q.push_back(b);
            repeat ($urandom_range(6)) q.push_back(8'($urandom_range(255)));
         end else if (r < 88) begin
            make_msg(q, plen, (ntags == 0) ? 1 : ntags, 1'b1);
         end else if (r < 93) begin
            make_msg(q, plen, $urandom_range(20, 17), 1'b0);
         end else begin
            repeat ($urandom_range(12, 1)) q.push_back(8'($urandom_range(255)));
         end
         send_dgram(q);
         sent += q.size();
         if ($urandom_range(11) == 0) hold_until_drained();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/osd_pkg.sv
hdl/osd_parser.sv
hdl/osd_out_queue.sv
hdl/osc_message_deframer_top.sv
test/tb.sv
